### rtl/fdssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdssd_pkg;

  localparam int unsigned RemWidth = 14;
  localparam int unsigned MaxDigit = 9;
  localparam logic [1:0]  LastStep = 2'd3;
  localparam logic signed [15:0] ValueLimit = 16'sd10000;

  typedef struct packed {
    logic [1:0] pos;
    logic [3:0] bcd;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t item;
  } wr_t;

  function automatic logic [RemWidth-1:0] step_weight(input logic [1:0] step);
    logic [RemWidth-1:0] w;
    unique case (step)
      2'd0: w = 14'd1000;
      2'd1: w = 14'd100;
      2'd2: w = 14'd10;
      2'd3: w = 14'd1;
    endcase
    return w;
  endfunction

  function automatic logic [6:0] seg_of(input logic [3:0] bcd);
    logic [6:0] s;
    unique case (bcd)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/fdssd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fdssd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic signed [15:0]  value_i,
  output fdssd_pkg::wr_t           wr_o,
  input  wire logic                q_full_i
);
  import fdssd_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e              state_q, state_d;
  logic [1:0]          step_q, step_d;
  logic [RemWidth-1:0] rem_q, rem_d;
  logic                started_q, started_d;

  logic [RemWidth-1:0] weight;
  logic [RemWidth-1:0] sub;
  logic [3:0]          qdig;
  logic                emit, advance, finish, accept, in_range;

  always_comb begin
    weight = step_weight(step_q);
    qdig   = '0;
    sub    = '0;
    for (int k = 1; k <= MaxDigit; k++) begin
      if (rem_q >= RemWidth'(RemWidth'(k) * weight)) begin
        qdig = 4'(k);
        sub  = RemWidth'(RemWidth'(k) * weight);
      end
    end

    emit     = (qdig != 4'd0) || started_q || (step_q == LastStep);
    advance  = (state_q == ST_RUN) && (!emit || !q_full_i);
    finish   = advance && (step_q == LastStep);
    full_o   = (state_q == ST_RUN) && !finish;
    accept   = push_i && !full_o;
    in_range = !value_i[15] && (value_i < ValueLimit);

    state_d   = state_q;
    step_d    = step_q;
    rem_d     = rem_q;
    started_d = started_q;
    if (advance) begin
      rem_d     = rem_q - sub;
      step_d    = step_q + 2'd1;
      started_d = started_q || emit;
    end
    if (finish) begin
      state_d = ST_IDLE;
    end
    if (accept && in_range) begin
      state_d   = ST_RUN;
      rem_d     = value_i[RemWidth-1:0];
      step_d    = '0;
      started_d = 1'b0;
    end

    wr_o.push      = (state_q == ST_RUN) && emit && !q_full_i;
    wr_o.item.pos  = step_q;
    wr_o.item.bcd  = qdig;
    wr_o.item.last = (step_q == LastStep);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      rem_q     <= rem_d;
      started_q <= started_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.push |-> !q_full_i) else $error("front pushed into a full queue");

  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !wr_o.push) else $error("front pushed while idle");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.push |-> (wr_o.item.bcd <= 4'd9)) else $error("digit out of range");

endmodule

`default_nettype wire

### rtl/fdssd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fdssd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fdssd_pkg::wr_t    wr_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output fdssd_pkg::entry_t      item_o
);
  import fdssd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  always_comb begin
    full_o  = (cnt_q == CntFull);
    empty_o = (cnt_q == '0);
    item_o  = mem_q[rptr_q];
    do_wr   = wr_i.push && !full_o;
    do_rd   = pop_i && !empty_o;

    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_i.item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull) else $error("queue count over depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count did not advance on write");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (rptr_q == wptr_q)) else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

### rtl/fdssd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fdssd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire fdssd_pkg::entry_t q_item_i,
  output logic                   q_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [1:0]             digit_position_o,
  output logic [6:0]             segments_o,
  output logic                   last_o
);
  import fdssd_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] pos_q;
  logic [6:0] seg_q;
  logic       last_q;

  always_comb begin
    empty_o = !valid_q;
    q_pop_o = !q_empty_i && (!valid_q || pop_i);
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pos_q  <= q_item_i.pos;
      seg_q  <= seg_of(q_item_i.bcd);
      last_q <= q_item_i.last;
    end
  end

  assign digit_position_o = pos_q;
  assign segments_o       = seg_q;
  assign last_o           = last_q;

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> valid_q) else $error("result register not filled after load");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (pos_q == LastStep)) else $error("last flag off rightmost digit");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop_i) |=> (valid_q && $stable(pos_q) && $stable(seg_q) && $stable(last_q)))
    else $error("waiting result changed");

endmodule

`default_nettype wire

### rtl/four_digit_seven_segment_driver.sv
// Channel   Direction  Handshake             Payload
// input     in         push / full           value_i (16, signed)
// result    out        empty / pop           digit_position_o, segments_o, last_o
//
// A value in 0..9999 occupies the front, one decimal digit a cycle while the
// queue is not full, from the compare-subtract digit unit; other values are
// dropped on accept. Each digit passes from the queue into the result register.
// Reset (rst_ni, async, active low) empties the queue and the result register.
// A full queue holds the front; a held result register stalls only the queue.
`timescale 1ns / 1ps
`default_nettype none

module four_digit_seven_segment_driver #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] value_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              digit_position_o,
  output logic [6:0]              segments_o,
  output logic                    last_o
);
  import fdssd_pkg::*;

  wr_t    wr;
  logic   q_full, q_empty, q_pop;
  entry_t q_item;

  fdssd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .value_i  (value_i),
    .wr_o     (wr),
    .q_full_i (q_full)
  );

  fdssd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  fdssd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .digit_position_o (digit_position_o),
    .segments_o       (segments_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
